@@ rtl/hsfc_pkg.sv @@
// ----------------------------------------------------------------------------
// hsfc_pkg
// Shared types, register indexes and the byte-wide CRC-32/MPEG-2 update for
// the header-synchronized frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package hsfc_pkg;

    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // configuration register indexes
    localparam logic [1:0] REG_HEADER_PATTERN = 2'd0;
    localparam logic [1:0] REG_CHECK_MODE     = 2'd1;
    localparam logic [1:0] REG_FRAME_LENGTH   = 2'd2;

    localparam logic [31:0] HEADER_PATTERN_RST = 32'hFE81_FF55;
    localparam logic        CHECK_MODE_RST     = 1'b0;
    localparam logic [7:0]  FRAME_LENGTH_RST   = 8'd36;

    localparam logic CHECK_CRC = 1'b0;
    localparam logic CHECK_SUM = 1'b1;

    typedef struct packed {
        logic [31:0] header_pattern;
        logic        check_mode;
        logic [7:0]  frame_length;
    } t_cfg;

    typedef struct packed {
        logic       check_ok;
        logic       frame_end;
        logic [7:0] frame_byte;
    } t_result;

    // MSB-first CRC update over one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'h000000};
        for (int k = 0; k < 8; k++) begin
            if (c[31]) begin
                c = {c[30:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[30:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/hsfc_frame.sv @@
// ----------------------------------------------------------------------------
// hsfc_frame
// Header hunt, frame position tracking and CRC / sum trailer check. One byte
// is processed in the cycle it is accepted; the result goes to the output
// buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module hsfc_frame #(
    parameter int HEADER_LENGTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [7:0]       i_byte,
    input  wire hsfc_pkg::t_cfg   i_cfg,
    output hsfc_pkg::t_result     o_res,
    output logic                  o_res_valid
);
    import hsfc_pkg::*;

    logic [2:0]  r_match,   n_match;
    logic        r_in_frame, n_in_frame;
    logic [7:0]  r_count,   n_count;
    logic [31:0] r_crc,     n_crc;
    logic [7:0]  r_sum,     n_sum;
    logic [31:0] r_trailer, n_trailer;

    logic [2:0] tlen;
    logic [8:0] min_len;
    logic [8:0] len;
    logic [8:0] body_end;
    logic [8:0] last_pos;
    logic [8:0] pos;
    logic [7:0] hdr_byte;
    logic [2:0] match_inc;

    always_comb begin
        case (r_match[1:0])
            2'd0:    hdr_byte = i_cfg.header_pattern[31:24];
            2'd1:    hdr_byte = i_cfg.header_pattern[23:16];
            2'd2:    hdr_byte = i_cfg.header_pattern[15:8];
            default: hdr_byte = i_cfg.header_pattern[7:0];
        endcase
    end

    assign tlen      = (i_cfg.check_mode == CHECK_SUM) ? 3'd1 : 3'd4;
    assign min_len   = 9'(HEADER_LENGTH) + {6'd0, tlen};
    assign len       = ({1'b0, i_cfg.frame_length} < min_len) ? min_len
                                                               : {1'b0, i_cfg.frame_length};
    assign body_end  = len - {6'd0, tlen};
    assign last_pos  = len - 9'd1;
    assign pos       = {1'b0, r_count};
    assign match_inc = r_match + 3'd1;

    always_comb begin
        n_match     = r_match;
        n_in_frame  = r_in_frame;
        n_count     = r_count;
        n_crc       = r_crc;
        n_sum       = r_sum;
        n_trailer   = r_trailer;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_valid) begin
            if (!r_in_frame) begin
                if (r_match < 3'(HEADER_LENGTH) && i_byte == hdr_byte) begin
                    n_crc   = crc_byte(r_crc, i_byte);
                    n_sum   = r_sum + i_byte;
                    n_match = match_inc;
                    if (match_inc >= 3'(HEADER_LENGTH)) begin
                        n_in_frame = 1'b1;
                        n_count    = 8'(HEADER_LENGTH);
                    end
                end else begin
                    // drop the partial header and restart the hunt
                    n_match    = '0;
                    n_in_frame = 1'b0;
                    n_count    = '0;
                    n_crc      = CRC_INIT;
                    n_sum      = '0;
                    n_trailer  = '0;
                end
            end else begin
                o_res_valid      = 1'b1;
                o_res.frame_byte = i_byte;
                if (pos < body_end) begin
                    n_crc = crc_byte(r_crc, i_byte);
                    n_sum = r_sum + i_byte;
                end else begin
                    n_trailer = {r_trailer[23:0], i_byte};
                end

                if (pos >= last_pos) begin
                    o_res.frame_end = 1'b1;
                    if (i_cfg.check_mode == CHECK_SUM) begin
                        o_res.check_ok = (n_sum == n_trailer[7:0]);
                    end else begin
                        o_res.check_ok = (n_crc == n_trailer);
                    end
                    n_match    = '0;
                    n_in_frame = 1'b0;
                    n_count    = '0;
                    n_crc      = CRC_INIT;
                    n_sum      = '0;
                    n_trailer  = '0;
                end else begin
                    n_count = r_count + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match    <= '0;
            r_in_frame <= 1'b0;
            r_count    <= '0;
            r_crc      <= CRC_INIT;
            r_sum      <= '0;
            r_trailer  <= '0;
        end else begin
            r_match    <= n_match;
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
            r_crc      <= n_crc;
            r_sum      <= n_sum;
            r_trailer  <= n_trailer;
        end
    end

    a_match_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_match <= 3'(HEADER_LENGTH))
        else $error("header match count beyond header length");

    a_ok_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.check_ok) |-> o_res.frame_end)
        else $error("check_ok raised without frame_end");

    a_count_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_frame |-> (r_count >= 8'(HEADER_LENGTH)))
        else $error("frame position behind the header while in frame");

    a_no_result_hunting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> !o_res_valid)
        else $error("result produced during header hunt");

endmodule

`default_nettype wire

@@ rtl/hsfc_out_buf.sv @@
// ----------------------------------------------------------------------------
// hsfc_out_buf
// Two-entry result buffer between the frame logic and the master stream, so
// the input keeps flowing while a result waits for the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module hsfc_out_buf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire hsfc_pkg::t_result i_res,
    output logic                   o_ready,
    output logic                   o_valid,
    output hsfc_pkg::t_result      o_res,
    input  wire logic              i_pop_ready
);
    import hsfc_pkg::*;

    t_result    r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt,  n_cnt;
    logic       pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_res   = r_mem[r_rptr];
    assign pop     = o_valid && i_pop_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= n_cnt;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("result buffer count overflow");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !i_push)
        else $error("push into full result buffer");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) |-> (r_wptr != r_rptr))
        else $error("pointers disagree with count");

endmodule

`default_nettype wire

@@ rtl/header_sync_frame_crc_checker.sv @@
// ----------------------------------------------------------------------------
// header_sync_frame_crc_checker
// Hunts a configured header in a byte stream, forwards the bytes of each
// frame after the header and flags frame end with a CRC-32 or sum verdict.
//
// Slave stream: one received byte per transaction in s_tdata. Header bytes
// and bytes seen while hunting produce no output. Every frame byte after
// the header, trailer included, produces one master transaction: tdata is
// the byte, tlast marks the final frame byte, tuser is the check verdict
// (meaningful with tlast, zero otherwise).
// Throughput is one byte per cycle unless the result buffer is full; the
// byte-wide CRC update and the frame position compare sit between the
// accepted byte and the result buffer, which registers each result.
// A two-entry result buffer decouples the sides: when the receiver stalls,
// up to two results wait in it; with both entries full s_tready drops until
// a result leaves.
// Configuration port: write index 0 header pattern, 1 check mode, 2 frame
// length; always ready. Write it only while idle; the block does not check.
// Reset (synchronous, active low) restores register defaults, restarts the
// hunt and empties the result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module header_sync_frame_crc_checker #(
    parameter int HEADER_LENGTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    // master stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,   // [7:0] frame_byte
    output logic             o_m_tlast,   // frame_end
    output logic             o_m_tuser,   // [0] check_ok
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import hsfc_pkg::*;

    t_cfg    r_cfg;
    t_result frame_res;
    t_result buf_res;
    logic    frame_res_valid;
    logic    s_accept;

    assign o_cfg_ready = 1'b1;
    assign s_accept    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_pattern <= HEADER_PATTERN_RST;
            r_cfg.check_mode     <= CHECK_MODE_RST;
            r_cfg.frame_length   <= FRAME_LENGTH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_HEADER_PATTERN: r_cfg.header_pattern <= i_cfg_data;
                REG_CHECK_MODE:     r_cfg.check_mode     <= i_cfg_data[0];
                REG_FRAME_LENGTH:   r_cfg.frame_length   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    hsfc_frame #(
        .HEADER_LENGTH (HEADER_LENGTH)
    ) u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_accept),
        .i_byte      (i_s_tdata),
        .i_cfg       (r_cfg),
        .o_res       (frame_res),
        .o_res_valid (frame_res_valid)
    );

    hsfc_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (frame_res_valid),
        .i_res       (frame_res),
        .o_ready     (o_s_tready),
        .o_valid     (o_m_tvalid),
        .o_res       (buf_res),
        .i_pop_ready (i_m_tready)
    );

    assign o_m_tdata = buf_res.frame_byte;
    assign o_m_tlast = buf_res.frame_end;
    assign o_m_tuser = buf_res.check_ok;

endmodule

`default_nettype wire
